@@ hw/rtl/buffer_pool_frame_manager_assert.svh @@
// Assertion macros used by the checker file
`ifndef BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH
`define BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BPFM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame manager check failed");

// Consequent must hold in the cycle after the antecedent
`define BPFM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame manager check failed");

`endif

@@ hw/rtl/bpfm_pkg.sv @@
`default_nettype none
package bpfm_pkg;
   localparam int MAX_FRAMES  = 8;
   localparam int FRAME_BITS  = 3;
   localparam int NACT_BITS   = 4;
   localparam int PAGE_BITS   = 10;
   localparam int QUEUE_DEPTH = 8;
   localparam int PIN_BITS    = 4;
   localparam int AGE_BITS    = 16;
   localparam int CNT_BITS    = 32;
   localparam int SWEEP_BITS  = 5;

   localparam logic [1:0] CMD_REQUEST = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_HOLD    = 2'd2;
   localparam logic [1:0] CMD_UNHOLD  = 2'd3;

   localparam logic [1:0] POL_LRU = 2'd0;
   localparam logic [1:0] POL_MRU = 2'd1;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_NOFREE = 3'd1;
   localparam logic [2:0] ST_NOTRES = 3'd2;
   localparam logic [2:0] ST_NOTUSE = 3'd3;
   localparam logic [2:0] ST_HELD   = 3'd4;
   localparam logic [2:0] ST_UNHELD = 3'd5;
   localparam logic [2:0] ST_FULL   = 3'd6;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_ACTIVE = 1'b1;

   typedef struct packed {
      logic latch;
      logic scan_init;
      logic scan_step;
      logic sweep_step;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic clock_mode;
      logic scan_last;
      logic best_valid;
      logic sweep_hit;
      logic sweep_last;
   } ctrl_stat_type;
endpackage
`default_nettype wire

@@ hw/rtl/bpfm_ctrl.sv @@
`default_nettype none
module bpfm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire bpfm_pkg::ctrl_stat_type stat,
   output bpfm_pkg::ctrl_cmd_type       cmd
);
   import bpfm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOOK  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SWEEP = 5'b01000,
      S_APPLY = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // sequence one transaction: lookup, victim scan, clock sweep, update
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.scan_init = 1'b1;
            state_in = stat.need_scan ? S_SCAN : S_APPLY;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = stat.clock_mode ? S_SWEEP : S_APPLY;
         end
         S_SWEEP: begin
            if (!stat.best_valid) begin
               state_in = S_APPLY;
            end else begin
               cmd.sweep_step = 1'b1;
               if (stat.sweep_hit || stat.sweep_last) state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/bpfm_datapath.sv @@
`default_nettype none
module bpfm_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bpfm_pkg::ctrl_cmd_type  cmd,
   output bpfm_pkg::ctrl_stat_type      stat,
   input  wire logic                    csr_write_enable,
   input  wire logic                    csr_index,
   input  wire logic [3:0]              csr_write_data,
   input  wire logic [1:0]              req_cmd,
   input  wire logic [bpfm_pkg::PAGE_BITS-1:0] req_page_id,
   input  wire logic                    req_is_write,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_hit,
   output logic [bpfm_pkg::FRAME_BITS-1:0] rsp_frame_index,
   output logic                         rsp_evicted_valid,
   output logic [bpfm_pkg::PAGE_BITS-1:0] rsp_evicted_page,
   output logic                         rsp_released_write,
   output logic                         rsp_frame_held,
   output logic [bpfm_pkg::CNT_BITS-1:0] rsp_hit_count,
   output logic [bpfm_pkg::CNT_BITS-1:0] rsp_request_count
);
   import bpfm_pkg::*;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   logic [1:0]           policy_ff;
   logic [NACT_BITS-1:0] active_ff;

   logic [1:0]           op_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 wr_ff;

   logic [PAGE_BITS-1:0]   page_ff_a [MAX_FRAMES], page_in [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  valid_ff, valid_in;
   logic [PIN_BITS-1:0]    pin_ff [MAX_FRAMES], pin_in [MAX_FRAMES];
   logic [QUEUE_DEPTH-1:0] fifo_ff [MAX_FRAMES], fifo_in [MAX_FRAMES];
   logic [PIN_BITS-1:0]    wcnt_ff [MAX_FRAMES], wcnt_in [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  dirty_ff, dirty_in;
   logic [MAX_FRAMES-1:0]  held_ff, held_in;
   logic [MAX_FRAMES-1:0]  ref_ff, ref_in;
   logic [AGE_BITS-1:0]    age_ff [MAX_FRAMES], age_in [MAX_FRAMES];
   logic [FRAME_BITS-1:0]  hand_ff, hand_in;
   logic [CNT_BITS-1:0]    hits_ff, hits_in;
   logic [CNT_BITS-1:0]    reqs_ff, reqs_in;

   logic [FRAME_BITS-1:0] scan_idx_ff;
   logic [FRAME_BITS-1:0] best_ff;
   logic [AGE_BITS-1:0]   best_age_ff;
   logic                  best_valid_ff;
   logic [SWEEP_BITS-1:0] sweep_cnt_ff;
   logic [FRAME_BITS-1:0] vic_ff;
   logic                  vic_found_ff;

   logic [MAX_FRAMES-1:0] elig;
   logic [NACT_BITS-1:0]  n_act;
   logic [FRAME_BITS-1:0] last_idx;
   logic                  clock_mode;
   logic                  match_any;
   logic [FRAME_BITS-1:0] match_idx;

   // saturate the active count and mark replaceable frames
   always_comb begin
      if (active_ff == '0) n_act = NACT_BITS'(1);
      else if (active_ff > NACT_BITS'(MAX_FRAMES)) n_act = NACT_BITS'(MAX_FRAMES);
      else n_act = active_ff;
      last_idx = FRAME_BITS'(n_act - NACT_BITS'(1));
      clock_mode = !(policy_ff == POL_LRU || policy_ff == POL_MRU);
      for (int i = 0; i < MAX_FRAMES; i++) elig[i] = (pin_ff[i] == '0) && !held_ff[i];
   end

   // look the page up across all frames, lowest index wins
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && page_ff_a[i] == page_ff) begin
            match_any = 1'b1;
            match_idx = FRAME_BITS'(i);
         end
      end
   end

   logic [FRAME_BITS-1:0] hand_eff;
   logic [FRAME_BITS-1:0] hand_next;
   logic                  scan_take;

   always_comb begin
      hand_eff = ({1'b0, hand_ff} >= n_act) ? '0 : hand_ff;
      hand_next = (hand_eff == last_idx) ? '0 : FRAME_BITS'(hand_eff + FRAME_BITS'(1));
      scan_take = elig[scan_idx_ff] &&
                  (!best_valid_ff || clock_mode ||
                   (policy_ff == POL_LRU ? age_ff[scan_idx_ff] > best_age_ff
                                         : age_ff[scan_idx_ff] < best_age_ff));
   end

   assign stat.need_scan  = (op_ff == CMD_REQUEST) && !match_any;
   assign stat.clock_mode = clock_mode;
   assign stat.scan_last  = (scan_idx_ff == last_idx);
   assign stat.best_valid = best_valid_ff;
   assign stat.sweep_hit  = elig[hand_eff] && !ref_ff[hand_eff];
   assign stat.sweep_last = (sweep_cnt_ff == SWEEP_BITS'({n_act, 1'b0}));

   // apply the operation to the chosen frame
   logic [FRAME_BITS-1:0] f;
   logic [2:0]            st;
   logic                  do_hit, do_fill, do_rel, do_hold, do_unhold, do_age;
   logic                  relw, fh;
   logic [PIN_BITS-1:0]   wc_dec;

   always_comb begin
      f = match_idx;
      st = ST_OK;
      do_hit = 1'b0; do_fill = 1'b0; do_rel = 1'b0; do_hold = 1'b0; do_unhold = 1'b0;
      relw = 1'b0; fh = 1'b0;
      case (op_ff)
         CMD_REQUEST: begin
            if (match_any) begin
               if (pin_ff[match_idx] >= PIN_BITS'(QUEUE_DEPTH)) st = ST_FULL;
               else do_hit = 1'b1;
            end else if (best_valid_ff) begin
               f = (clock_mode && vic_found_ff) ? vic_ff : best_ff;
               do_fill = 1'b1;
            end else begin
               f = '0;
               st = ST_NOFREE;
            end
         end
         default: begin
            if (!match_any) begin
               f = '0;
               st = ST_NOTRES;
            end else if (op_ff == CMD_RELEASE) begin
               if (pin_ff[match_idx] == '0) begin
                  st = ST_NOTUSE;
                  fh = held_ff[match_idx];
               end else begin
                  do_rel = 1'b1;
                  relw = fifo_ff[match_idx][0];
               end
            end else if (op_ff == CMD_HOLD) begin
               if (held_ff[match_idx]) st = ST_HELD;
               else do_hold = 1'b1;
            end else begin
               if (!held_ff[match_idx]) st = ST_UNHELD;
               else do_unhold = 1'b1;
            end
         end
      endcase
      do_age = do_hit || do_fill || do_rel;
      wc_dec = (relw && wcnt_ff[f] != '0) ? PIN_BITS'(wcnt_ff[f] - PIN_BITS'(1)) : wcnt_ff[f];
   end

   // next frame state for an apply cycle or a sweep step
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         page_in[i] = page_ff_a[i];
         pin_in[i] = pin_ff[i];
         fifo_in[i] = fifo_ff[i];
         wcnt_in[i] = wcnt_ff[i];
         age_in[i] = age_ff[i];
      end
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      held_in = held_ff;
      ref_in = ref_ff;
      hand_in = hand_ff;
      hits_in = hits_ff;
      reqs_in = reqs_ff;

      if (cmd.sweep_step) begin
         hand_in = hand_next;
         if (elig[hand_eff]) ref_in[hand_eff] = 1'b0;
      end

      if (cmd.apply) begin
         if (do_fill) begin
            page_in[f] = page_ff;
            valid_in[f] = 1'b1;
            pin_in[f] = PIN_BITS'(1);
            fifo_in[f] = QUEUE_DEPTH'(wr_ff);
            wcnt_in[f] = PIN_BITS'(wr_ff);
            dirty_in[f] = wr_ff;
            ref_in[f] = 1'b1;
            age_in[f] = '0;
         end
         if (do_hit) begin
            if (wr_ff) begin
               fifo_in[f] = fifo_ff[f] | (QUEUE_DEPTH'(1) << pin_ff[f][FRAME_BITS-1:0]);
               wcnt_in[f] = PIN_BITS'(wcnt_ff[f] + PIN_BITS'(1));
               dirty_in[f] = 1'b1;
            end
            ref_in[f] = 1'b1;
            age_in[f] = '0;
            pin_in[f] = PIN_BITS'(pin_ff[f] + PIN_BITS'(1));
            if (hits_ff != CNT_MAX) hits_in = hits_ff + CNT_BITS'(1);
         end
         if (do_rel) begin
            fifo_in[f] = fifo_ff[f] >> 1;
            wcnt_in[f] = wc_dec;
            age_in[f] = '0;
            pin_in[f] = PIN_BITS'(pin_ff[f] - PIN_BITS'(1));
            if (wc_dec == '0) dirty_in[f] = 1'b0;
         end
         if (do_hold) held_in[f] = 1'b1;
         if (do_unhold) held_in[f] = 1'b0;
         if ((do_hit || do_fill) && reqs_ff != CNT_MAX) reqs_in = reqs_ff + CNT_BITS'(1);
         // age every frame that is not held
         if (do_age) begin
            for (int i = 0; i < MAX_FRAMES; i++)
               if (!held_in[i] && age_in[i] != AGE_MAX)
                  age_in[i] = AGE_BITS'(age_in[i] + AGE_BITS'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 2'd2;
         active_ff <= NACT_BITS'(4);
         for (int i = 0; i < MAX_FRAMES; i++) begin
            page_ff_a[i] <= '0;
            pin_ff[i] <= '0;
            fifo_ff[i] <= '0;
            wcnt_ff[i] <= '0;
            age_ff[i] <= '0;
         end
         valid_ff <= '0;
         dirty_ff <= '0;
         held_ff <= '0;
         ref_ff <= '0;
         hand_ff <= '0;
         hits_ff <= '0;
         reqs_ff <= '0;
         rsp_valid <= 1'b0;
         best_valid_ff <= 1'b0;
         vic_found_ff <= 1'b0;
         scan_idx_ff <= '0;
         sweep_cnt_ff <= '0;
      end else begin
         // configuration writes
         if (csr_write_enable) begin
            if (csr_index == CSR_POLICY) policy_ff <= csr_write_data[1:0];
            else active_ff <= csr_write_data;
         end
         for (int i = 0; i < MAX_FRAMES; i++) begin
            page_ff_a[i] <= page_in[i];
            pin_ff[i] <= pin_in[i];
            fifo_ff[i] <= fifo_in[i];
            wcnt_ff[i] <= wcnt_in[i];
            age_ff[i] <= age_in[i];
         end
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         held_ff <= held_in;
         ref_ff <= ref_in;
         hand_ff <= hand_in;
         hits_ff <= hits_in;
         reqs_ff <= reqs_in;
         rsp_valid <= cmd.apply;

         // victim scan over the active frames, one per cycle
         if (cmd.scan_init) begin
            scan_idx_ff <= '0;
            best_valid_ff <= 1'b0;
            sweep_cnt_ff <= '0;
            vic_found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= FRAME_BITS'(scan_idx_ff + FRAME_BITS'(1));
            if (scan_take) begin
               best_ff <= scan_idx_ff;
               best_age_ff <= age_ff[scan_idx_ff];
               best_valid_ff <= 1'b1;
            end
         end
         // clock hand advances one frame per cycle
         if (cmd.sweep_step) begin
            sweep_cnt_ff <= SWEEP_BITS'(sweep_cnt_ff + SWEEP_BITS'(1));
            if (elig[hand_eff] && !ref_ff[hand_eff]) begin
               vic_ff <= hand_eff;
               vic_found_ff <= 1'b1;
            end
         end
      end
      // capture the transaction
      if (cmd.latch) begin
         op_ff <= req_cmd;
         page_ff <= req_page_id;
         wr_ff <= req_is_write;
      end
      // hold the result for its strobe cycle
      if (cmd.apply) begin
         rsp_status <= st;
         rsp_hit <= do_hit;
         rsp_frame_index <= f;
         rsp_evicted_valid <= do_fill && valid_ff[f];
         rsp_evicted_page <= (do_fill && valid_ff[f]) ? page_ff_a[f] : '0;
         rsp_released_write <= relw;
         rsp_frame_held <= fh;
         rsp_hit_count <= hits_in;
         rsp_request_count <= reqs_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/buffer_pool_frame_manager.sv @@
`default_nettype none
// Any transaction other than a request that misses goes from lookup straight to apply.
// A request that misses first scans each active frame for a victim, and under clock
// replacement then sweeps the hand until it finds an unreferenced frame or gives up.
// A new transaction is taken once busy is low, and rsp_valid pulses for one cycle since
// the receiver cannot stall.
// Synchronous active-high reset clears all frames, counters and the clock hand,
// and sets the policy to clock with four active frames.
module buffer_pool_frame_manager (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [bpfm_pkg::PAGE_BITS-1:0] req_page_id,
   input  wire logic        req_is_write,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic             rsp_hit,
   output logic [bpfm_pkg::FRAME_BITS-1:0] rsp_frame_index,
   output logic             rsp_evicted_valid,
   output logic [bpfm_pkg::PAGE_BITS-1:0] rsp_evicted_page,
   output logic             rsp_released_write,
   output logic             rsp_frame_held,
   output logic [bpfm_pkg::CNT_BITS-1:0] rsp_hit_count,
   output logic [bpfm_pkg::CNT_BITS-1:0] rsp_request_count,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_write_data
);
   import bpfm_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   bpfm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bpfm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_cmd            (req_cmd),
      .req_page_id        (req_page_id),
      .req_is_write       (req_is_write),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_released_write (rsp_released_write),
      .rsp_frame_held     (rsp_frame_held),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_request_count  (rsp_request_count)
   );
endmodule
`default_nettype wire

@@ hw/rtl/bpfm_checker.sv @@
`default_nettype none
`include "buffer_pool_frame_manager_assert.svh"
module bpfm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_hit,
   input wire logic       rsp_evicted_valid
);
   import bpfm_pkg::*;

   // an accepted transaction keeps the block busy
   `BPFM_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   // a result never shows while a transaction is in flight
   `BPFM_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   // one result per transaction, never back to back
   `BPFM_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // a hit is always a success
   `BPFM_ASSERT_SAME(a_hit_ok, clock, reset, rsp_valid && rsp_hit, rsp_status == ST_OK)
   // eviction only on a successful miss
   `BPFM_ASSERT_SAME(a_evict_ok, clock, reset, rsp_valid && rsp_evicted_valid,
                     rsp_status == ST_OK && !rsp_hit)
endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid)
);
`default_nettype wire
